@@ rtl/b32d_pkg.sv @@
`default_nettype none
package b32d_pkg;

  localparam int MaxOutBits = 1024;
  localparam int CntW = 11;

  typedef enum logic [1:0] {
    KindEnd = 2'd0,
    KindSym = 2'd1,
    KindBad = 2'd2,
    KindSkip = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhCollect = 2'b01,
    PhDrain   = 2'b10
  } phase_e;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] sym;
  } req_t;

  function automatic req_t classify(input logic [7:0] c);
    req_t r;
    r.kind = KindSym;
    r.sym  = 5'd0;
    case (c) inside
      8'h00:                         r.kind = KindEnd;
      [8'h09:8'h0D], 8'h20, 8'h2D:   r.kind = KindSkip;
      [8'h41:8'h48]:                 r.sym = 5'(c - 8'h41);
      [8'h4A:8'h4E]:                 r.sym = 5'(c - 8'h42);
      [8'h50:8'h5A]:                 r.sym = 5'(c - 8'h43);
      [8'h32:8'h39]:                 r.sym = 5'(c - 8'h1A);
      default:                       r.kind = KindBad;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/b32d_front.sv @@
`default_nettype none
module b32d_front (
  input  wire logic           in_valid_i,
  input  wire logic [7:0]     text_char_i,
  input  wire logic           full_i,
  output b32d_pkg::req_t      req_o,
  output logic                push_o,
  output logic                in_stall_o
);

  // whitespace and '-' are dropped here and never reach the queue
  assign req_o      = b32d_pkg::classify(text_char_i);
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && (req_o.kind != b32d_pkg::KindSkip);

endmodule
`default_nettype wire

@@ rtl/b32d_queue.sv @@
`default_nettype none
module b32d_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire b32d_pkg::req_t req_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output logic                full_o,
  output b32d_pkg::req_t      req_o
);

  b32d_pkg::req_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign req_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/b32d_back.sv @@
`default_nettype none
module b32d_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [b32d_pkg::CntW-1:0]    cfg_wdata_i,
  input  wire logic                         q_valid_i,
  input  wire b32d_pkg::req_t               q_req_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        data_byte_o,
  output logic                              byte_valid_o,
  output logic [6:0]                        byte_index_o,
  output logic                              finished_o,
  output logic                              decode_error_o,
  output logic [b32d_pkg::CntW-1:0]         total_bits_o
);

  localparam int W = b32d_pkg::CntW;
  localparam logic [W-1:0] MaxLim = W'(b32d_pkg::MaxOutBits);

  logic [W-1:0]      limit_q;
  logic [7:0]        partial_q, partial_d;
  logic [2:0]        bits_q, bits_d;
  logic [W-1:0]      total_q, total_d;
  b32d_pkg::phase_e  phase_q, phase_d;

  logic              out_valid_q;
  logic [7:0]        data_q, data_d;
  logic              bvalid_q, bvalid_d;
  logic [6:0]        index_q, index_d;
  logic              fin_q, fin_d;
  logic              err_q, err_d;
  logic [W-1:0]      otot_q, otot_d;
  logic              emit;

  logic [W-1:0]      lim, rem;
  logic [2:0]        sbits;
  logic [4:0]        symv;
  logic [15:0]       acc;
  logic [3:0]        n;
  logic              take;

  assign take  = !out_valid_q || !out_stall_i;
  assign pop_o = q_valid_i && take;

  always_comb begin
    lim   = (limit_q > MaxLim) ? MaxLim : limit_q;
    rem   = lim - total_q;
    sbits = (rem > W'(5)) ? 3'd5 : rem[2:0];
    symv  = q_req_i.sym >> (3'd5 - sbits);
    acc   = {partial_q, 8'h00} | (16'(symv) << (5'd16 - 5'(bits_q) - 5'(sbits)));
    n     = 4'(bits_q) + 4'(sbits);

    partial_d = partial_q;
    bits_d    = bits_q;
    total_d   = total_q;
    phase_d   = phase_q;
    emit      = 1'b0;
    data_d    = 8'h00;
    bvalid_d  = 1'b0;
    index_d   = 7'd0;
    fin_d     = 1'b0;
    err_d     = 1'b0;
    otot_d    = total_q;

    case (q_req_i.kind)
      b32d_pkg::KindEnd: begin
        if (phase_q == b32d_pkg::PhCollect) begin
          emit  = 1'b1;
          fin_d = 1'b1;
          if (bits_q != 3'd0) begin
            data_d   = partial_q;
            bvalid_d = 1'b1;
            index_d  = total_q[9:3];
          end
        end
        partial_d = 8'h00;
        bits_d    = 3'd0;
        total_d   = '0;
        phase_d   = b32d_pkg::PhCollect;
      end
      b32d_pkg::KindBad: begin
        if (phase_q == b32d_pkg::PhCollect) begin
          emit    = 1'b1;
          fin_d   = 1'b1;
          err_d   = 1'b1;
          phase_d = b32d_pkg::PhDrain;
        end
      end
      b32d_pkg::KindSym: begin
        if (phase_q == b32d_pkg::PhCollect) begin
          if (total_q >= lim) begin
            emit    = 1'b1;
            fin_d   = 1'b1;
            phase_d = b32d_pkg::PhDrain;
            if (bits_q != 3'd0) begin
              data_d   = partial_q;
              bvalid_d = 1'b1;
              index_d  = total_q[9:3];
            end
          end else begin
            total_d = total_q + W'(sbits);
            if (n >= 4'd8) begin
              emit      = 1'b1;
              data_d    = acc[15:8];
              bvalid_d  = 1'b1;
              index_d   = total_q[9:3];
              otot_d    = total_q + W'(sbits);
              partial_d = acc[7:0];
              bits_d    = 3'(n - 4'd8);
            end else begin
              partial_d = acc[15:8];
              bits_d    = n[2:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= MaxLim;
      partial_q   <= 8'h00;
      bits_q      <= 3'd0;
      total_q     <= '0;
      phase_q     <= b32d_pkg::PhCollect;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (pop_o) begin
        partial_q   <= partial_d;
        bits_q      <= bits_d;
        total_q     <= total_d;
        phase_q     <= phase_d;
        out_valid_q <= emit;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      data_q   <= data_d;
      bvalid_q <= bvalid_d;
      index_q  <= index_d;
      fin_q    <= fin_d;
      err_q    <= err_d;
      otot_q   <= otot_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_byte_o    = data_q;
  assign byte_valid_o   = bvalid_q;
  assign byte_index_o   = index_q;
  assign finished_o     = fin_q;
  assign decode_error_o = err_q;
  assign total_bits_o   = otot_q;

endmodule
`default_nettype wire

@@ rtl/base32_text_decoder.sv @@
`default_nettype none
// A character is registered in the queue, then its result in the back end.
// Throughput: one character per cycle while out_stall_i is low, set by the
// two-entry queue and the back end pack step; whitespace causes no result.
// Reset (rst_ni low, asynchronous): queue empty, output empty, string state
// cleared, bit limit back to 1024.
module base32_text_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [b32d_pkg::CntW-1:0]   cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [7:0]                  text_char_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [7:0]                       data_byte_o,
  output logic                             byte_valid_o,
  output logic [6:0]                       byte_index_o,
  output logic                             finished_o,
  output logic                             decode_error_o,
  output logic [b32d_pkg::CntW-1:0]        total_bits_o,
  output logic                             last_o
);

  b32d_pkg::req_t front_req, q_req;
  logic           push, full, q_valid, pop;

  b32d_front u_front (
    .in_valid_i  (in_valid_i),
    .text_char_i (text_char_i),
    .full_i      (full),
    .req_o       (front_req),
    .push_o      (push),
    .in_stall_o  (in_stall_o)
  );

  b32d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (full),
    .req_o   (q_req)
  );

  b32d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_valid_i      (q_valid),
    .q_req_i        (q_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .byte_index_o   (byte_index_o),
    .finished_o     (finished_o),
    .decode_error_o (decode_error_o),
    .total_bits_o   (total_bits_o)
  );

  // one result per character at most
  assign last_o = 1'b1;

endmodule
`default_nettype wire

@@ test/tb_base32_text_decoder.sv @@
`default_nettype none
module tb_base32_text_decoder;

  localparam int CntW = b32d_pkg::CntW;
  localparam int MaxOutBits = b32d_pkg::MaxOutBits;
  localparam int CycleLimit = 200000;
  localparam logic [7:0] EndOfText = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChPad = 8'h3D;

  typedef struct packed {
    logic [7:0]      data;
    logic            valid;
    logic [6:0]      index;
    logic            fin;
    logic            err;
    logic [CntW-1:0] total;
    logic            last;
  } byte_res_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       typed;
    byte_res_t  res;
  } dir_row_t;

  localparam dir_row_t DirRows [25] = '{
    '{8'h00, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b0, 11'd0, 1'b1}},
    '{8'h41, 1'b0, '0},
    '{8'h39, 1'b1, '{8'h07, 1'b1, 7'd0, 1'b0, 1'b0, 11'd10, 1'b1}},
    '{8'h20, 1'b0, '0},
    '{8'h09, 1'b0, '0},
    '{8'h0D, 1'b0, '0},
    '{8'h2D, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b1, '{8'hEE, 1'b1, 7'd1, 1'b1, 1'b0, 11'd15, 1'b1}},
    '{8'h3D, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b1, 11'd0, 1'b1}},
    '{8'h42, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h32, 1'b0, '0},
    '{8'h48, 1'b0, '0},
    '{8'h4A, 1'b0, '0},
    '{8'h4E, 1'b0, '0},
    '{8'h50, 1'b0, '0},
    '{8'h61, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b1, 11'd25, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h49, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b1, 11'd0, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h31, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b1, 11'd0, 1'b1}},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b1, '{8'h00, 1'b0, 7'd0, 1'b1, 1'b1, 11'd0, 1'b1}},
    '{8'h00, 1'b0, '0}
  };

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CntW-1:0] cfg_wdata_i;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [7:0]      text_char_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic [7:0]      data_byte_o;
  logic            byte_valid_o;
  logic [6:0]      byte_index_o;
  logic            finished_o;
  logic            decode_error_o;
  logic [CntW-1:0] total_bits_o;
  logic            last_o;

  base32_text_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_char_i    (text_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_byte_o    (data_byte_o),
    .byte_valid_o   (byte_valid_o),
    .byte_index_o   (byte_index_o),
    .finished_o     (finished_o),
    .decode_error_o (decode_error_o),
    .total_bits_o   (total_bits_o),
    .last_o         (last_o)
  );

  string sym_alphabet = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";

  // decoder state as predicted
  logic [7:0]       pk_partial;
  int               pk_nbits;
  int               pk_total;
  b32d_pkg::phase_e pk_phase;
  logic [CntW-1:0]  bit_limit;

  byte_res_t due_bytes[$];
  logic      idle_en;
  int        stall_run;
  int        cycle_count;
  int        n_sent;
  int        n_strings;
  int        n_checked;
  int        n_limits;
  int        n_errors;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_bytes.size());
      $display("base32_text_decoder test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (n_errors < 40) begin
      $display("mismatch at result %0d: %s got %0d expected %0d", n_checked, what, got, want);
    end
    n_errors++;
  endtask

  function automatic byte_res_t closing_result();
    byte_res_t r;
    r = '0;
    if (pk_nbits != 0) begin
      r.data  = pk_partial;
      r.valid = 1'b1;
      r.index = 7'(pk_total >> 3);
    end
    r.fin   = 1'b1;
    r.total = CntW'(pk_total);
    r.last  = 1'b1;
    return r;
  endfunction

  function automatic void clear_string();
    pk_partial = 8'h00;
    pk_nbits   = 0;
    pk_total   = 0;
    pk_phase   = b32d_pkg::PhCollect;
  endfunction

  function automatic bit decode_char(input logic [7:0] c, output byte_res_t r);
    int          sym;
    int          i;
    int          lim;
    int          take;
    logic [15:0] win;
    r = '0;
    r.last = 1'b1;
    if (c == EndOfText) begin
      if (pk_phase == b32d_pkg::PhCollect) begin
        r = closing_result();
        clear_string();
        return 1'b1;
      end
      clear_string();
      return 1'b0;
    end
    if (pk_phase != b32d_pkg::PhCollect) return 1'b0;
    if ((c >= 8'h09 && c <= 8'h0D) || c == ChSpace || c == ChDash) return 1'b0;
    sym = -1;
    for (i = 0; i < 32; i++) begin
      if (sym_alphabet[i] == c) sym = i;
    end
    if (sym < 0) begin
      r.fin    = 1'b1;
      r.err    = 1'b1;
      r.total  = CntW'(pk_total);
      pk_phase = b32d_pkg::PhDrain;
      return 1'b1;
    end
    lim = (bit_limit > MaxOutBits) ? MaxOutBits : int'(bit_limit);
    if (pk_total >= lim) begin
      r = closing_result();
      pk_phase = b32d_pkg::PhDrain;
      return 1'b1;
    end
    take = (lim - pk_total > 5) ? 5 : lim - pk_total;
    sym  = sym >> (5 - take);
    win  = {pk_partial, 8'h00} | (16'(sym) << (16 - pk_nbits - take));
    pk_total += take;
    if (pk_nbits + take >= 8) begin
      r.data     = win[15:8];
      r.valid    = 1'b1;
      r.index    = 7'((pk_total - take) >> 3);
      r.total    = CntW'(pk_total);
      pk_partial = win[7:0];
      pk_nbits   = pk_nbits + take - 8;
      return 1'b1;
    end
    pk_partial = win[15:8];
    pk_nbits   = pk_nbits + take;
    return 1'b0;
  endfunction

  function automatic logic [7:0] random_text_char(input bit clean);
    int w;
    w = $urandom_range(0, 99);
    if (w < 84 || (clean && w >= 92)) return sym_alphabet[$urandom_range(0, 31)];
    if (w < 92) begin
      w = $urandom_range(0, 6);
      return (w < 5) ? 8'(9 + w) : ((w == 5) ? ChSpace : ChDash);
    end
    if (w < 96) return 8'($urandom_range(1, 255));
    if (w < 98) return ChPad;
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic typed = 1'b0,
                           input byte_res_t want = '0);
    byte_res_t r;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_char_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_char(c, r)) due_bytes.push_back(typed ? want : r);
    n_sent++;
  endtask

  task automatic send_string(input int len, input bit clean, input bit terminate);
    int k;
    for (k = 0; k < len; k++) send_char(random_text_char(clean));
    if (terminate) begin
      send_char(EndOfText);
      n_strings++;
    end
  endtask

  // register writes only once nothing is in flight
  task automatic set_bit_limit(input logic [CntW-1:0] v);
    in_valid_i <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    bit_limit = v;
    n_limits++;
  endtask

  task automatic check_byte_result();
    byte_res_t want;
    if (due_bytes.size() == 0) begin
      report_mismatch("unexpected result, data_byte", data_byte_o, -1);
      return;
    end
    want = due_bytes.pop_front();
    if (data_byte_o !== want.data) report_mismatch("data_byte", data_byte_o, want.data);
    if (byte_valid_o !== want.valid) report_mismatch("byte_valid", byte_valid_o, want.valid);
    if (byte_index_o !== want.index) report_mismatch("byte_index", byte_index_o, want.index);
    if (finished_o !== want.fin) report_mismatch("finished", finished_o, want.fin);
    if (decode_error_o !== want.err) report_mismatch("decode_error", decode_error_o, want.err);
    if (total_bits_o !== want.total) report_mismatch("total_bits", total_bits_o, want.total);
    if (last_o !== want.last) report_mismatch("last", last_o, want.last);
    n_checked++;
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) check_byte_result();
    if (stall_run > 0) begin
      stall_run = stall_run - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_run = $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    int              i;
    int              p;
    int              phase_end;
    logic [CntW-1:0] lim;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    text_char_i = 8'h00;
    out_stall_i = 1'b0;
    idle_en     = 1'b0;
    stall_run   = 0;
    cycle_count = 0;
    n_sent      = 0;
    n_strings   = 0;
    n_checked   = 0;
    n_limits    = 0;
    n_errors    = 0;
    bit_limit   = CntW'(MaxOutBits);
    clear_string();
    repeat (5) @(posedge clk_i);
    rst_ni  <= 1'b1;
    idle_en <= 1'b1;

    for (i = 0; i < 25; i++) send_char(DirRows[i].ch, DirRows[i].typed, DirRows[i].res);

    for (p = 0; n_sent < 1040; p++) begin
      case (p)
        0: lim = 11'd1024;
        1: lim = 11'd0;
        2: lim = 11'd1;
        3: lim = 11'd2047;
        4: lim = 11'd8;
        5: lim = 11'd13;
        6: lim = 11'd1023;
        default: begin
          if ($urandom_range(0, 3) == 0) lim = CntW'($urandom_range(0, 2047));
          else lim = CntW'($urandom_range(0, 80));
        end
      endcase
      set_bit_limit(lim);
      idle_en <= (n_sent < 900) && ($urandom_range(0, 3) != 0);
      // full-length string runs the bit count up to the cap
      if (p == 0 || p == 3) begin
        send_char(EndOfText);
        send_string(240, 1'b1, 1'b1);
      end
      phase_end = n_sent + 60;
      while (n_sent < phase_end) send_string($urandom_range(0, 14), 1'b0, 1'b1);
      // leave a string open across the next limit change
      if ($urandom_range(0, 1) == 1) send_string($urandom_range(1, 8), 1'b0, 1'b0);
    end

    in_valid_i <= 1'b0;
    idle_en    <= 1'b0;
    for (i = 0; i < 1000 && due_bytes.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (due_bytes.size() != 0) report_mismatch("results never produced", 0, due_bytes.size());

    $display("%0d characters in %0d strings sent, %0d results checked", n_sent, n_strings,
             n_checked);
    $display("%0d bit limit settings including 0, 1, 8, 13, 1023, 1024 and 2047", n_limits);
    if (n_errors == 0) begin
      $display("base32_text_decoder test passed");
    end else begin
      $display("base32_text_decoder test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
